// ----- sv/drop_tail_queue_delay_tracker_core_assert.svh -----
// Assertion macros shared by the checker of the drop-tail queue tracker.
`ifndef DROP_TAIL_QUEUE_DELAY_TRACKER_CORE_ASSERT_SVH
`define DROP_TAIL_QUEUE_DELAY_TRACKER_CORE_ASSERT_SVH

// Clocked check, idle while reset is held.
`define DTQ_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dtq check failed");

// Clocked check that also holds across reset.
`define DTQ_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("dtq reset check failed");

`endif

// ----- sv/dtq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared widths, constants, register indexes and the result record of the
// drop-tail queue delay tracker.
// ----------------------------------------------------------------------------
package dtq_pkg;

  localparam int ARR_W   = 48;
  localparam int BYTES_W = 16;
  localparam int TPB_W   = 16;
  localparam int QLIM_W  = 8;
  localparam int FIN_W   = 56;
  localparam int SVC_W   = 32;
  localparam int WAIT_W  = 48;
  localparam int OCC_W   = 8;
  localparam int CNT_W   = 32;
  localparam int SUM_W   = 63;

  localparam int DEPTH_DEF = 128;

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] REG_TPB  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_QLIM = 1'b1;

  localparam logic [TPB_W-1:0]  TPB_RST  = 16'd1600;
  localparam logic [QLIM_W-1:0] QLIM_RST = 8'd100;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 216;

  localparam logic [FIN_W-1:0]  FIN_MAX  = {FIN_W{1'b1}};
  localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

  typedef struct packed {
    logic              accepted;
    logic [WAIT_W-1:0] wait_ticks;
    logic [OCC_W-1:0]  occupancy;
    logic [CNT_W-1:0]  incoming_count;
    logic [CNT_W-1:0]  delivered_count;
    logic [CNT_W-1:0]  dropped_count;
    logic [SUM_W-1:0]  total_wait;
  } dtq_result_t;

endpackage

// ----- sv/dtq_fin_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_fin_mem
// Finish-time store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dtq_fin_mem #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int DW    = 56
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/dtq_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_engine
// Sequencer and datapath: retire finished head packets one per cycle from
// the finish-time store, then enqueue or drop and load the result register.
// ----------------------------------------------------------------------------
module dtq_engine
  import dtq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [ARR_W-1:0]   in_arrival,
  input  logic [BYTES_W-1:0] in_bytes,
  input  logic [TPB_W-1:0]   ticks_per_byte,
  input  logic [QLIM_W-1:0]  queue_limit,
  output logic               out_valid,
  input  logic               out_ready,
  output dtq_result_t        out_result,
  output logic               mem_wr_en,
  output logic [AW-1:0]      mem_wr_addr,
  output logic [FIN_W-1:0]   mem_wr_data,
  output logic [AW-1:0]      mem_rd_addr,
  input  logic [FIN_W-1:0]   mem_rd_data
);

  localparam int LW = (CW > QLIM_W) ? CW : QLIM_W;
  localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic              state_r, state_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [AW-1:0]     tail_r, tail_nxt;
  logic [CW-1:0]     held_r, held_nxt;
  logic [FIN_W-1:0]  tail_fin_r, tail_fin_nxt;
  logic [FIN_W-1:0]  arr_r, start_r;
  logic [WAIT_W-1:0] wait_r;
  logic [SVC_W-1:0]  service_r;
  logic [CNT_W-1:0]  seen_r, seen_nxt;
  logic [CNT_W-1:0]  deliv_r, deliv_nxt;
  logic [CNT_W-1:0]  drop_r, drop_nxt;
  logic [SUM_W-1:0]  wsum_r, wsum_nxt;
  logic              out_valid_r, out_valid_nxt;
  dtq_result_t       res_r, res_nxt;

  logic              take;
  logic [FIN_W-1:0]  in_arr_ext, in_diff;
  logic              in_gt;
  logic              pop_go, commit, admit;
  logic [LW-1:0]     limit, qlim_ext, held_ext;
  logic [FIN_W:0]    fin_sum;
  logic [FIN_W-1:0]  fin;
  logic [SUM_W:0]    wsum_add;
  logic [CW-1:0]     held_after;

  function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p);
    next_pos = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign in_ready = (state_r == ST_IDLE);
  assign take     = in_valid && in_ready;

  // Waiting delay and start time against the current tail, taken at accept.
  assign in_arr_ext = FIN_W'(in_arrival);
  assign in_gt      = (held_r != '0) && (tail_fin_r > in_arr_ext);
  assign in_diff    = tail_fin_r - in_arr_ext;

  assign pop_go  = (state_r == ST_RUN) && (held_r != '0) && (mem_rd_data <= arr_r);
  assign commit  = (state_r == ST_RUN) && !pop_go && (!out_valid_r || out_ready);

  assign qlim_ext = LW'(queue_limit);
  assign limit    = (qlim_ext > DEPTH_L) ? DEPTH_L : qlim_ext;
  assign held_ext = LW'(held_r);
  assign admit    = held_ext < limit;

  assign fin_sum  = {1'b0, start_r} + (FIN_W + 1)'(service_r);
  assign fin      = fin_sum[FIN_W] ? FIN_MAX : fin_sum[FIN_W-1:0];
  assign wsum_add = {1'b0, wsum_r} + (SUM_W + 1)'(wait_r);
  assign held_after = admit ? held_r + CW'(1) : held_r;

  // Read the head the next cycle will see; writes land well before that
  // entry is read again, since every item opens with an accept cycle.
  assign mem_rd_addr = head_nxt;
  assign mem_wr_en   = commit && admit;
  assign mem_wr_addr = tail_r;
  assign mem_wr_data = fin;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    held_nxt      = held_r;
    tail_fin_nxt  = tail_fin_r;
    seen_nxt      = seen_r;
    deliv_nxt     = deliv_r;
    drop_nxt      = drop_r;
    wsum_nxt      = wsum_r;
    out_valid_nxt = out_valid_r && !out_ready;
    res_nxt       = res_r;
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (pop_go) begin
          head_nxt = next_pos(head_r);
          held_nxt = held_r - CW'(1);
        end else if (commit) begin
          state_nxt = ST_IDLE;
          seen_nxt  = (seen_r == CNT_MAX) ? seen_r : seen_r + 1'b1;
          res_nxt.accepted = admit;
          if (admit) begin
            tail_nxt     = next_pos(tail_r);
            held_nxt     = held_after;
            tail_fin_nxt = fin;
            deliv_nxt    = (deliv_r == CNT_MAX) ? deliv_r : deliv_r + 1'b1;
            wsum_nxt     = wsum_add[SUM_W] ? SUM_MAX : wsum_add[SUM_W-1:0];
            res_nxt.wait_ticks = wait_r;
          end else begin
            drop_nxt = (drop_r == CNT_MAX) ? drop_r : drop_r + 1'b1;
            res_nxt.wait_ticks = '0;
          end
          res_nxt.occupancy       = OCC_W'(held_after);
          res_nxt.incoming_count  = seen_nxt;
          res_nxt.delivered_count = deliv_nxt;
          res_nxt.dropped_count   = drop_nxt;
          res_nxt.total_wait      = wsum_nxt;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      held_r      <= '0;
      seen_r      <= '0;
      deliv_r     <= '0;
      drop_r      <= '0;
      wsum_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      held_r      <= held_nxt;
      seen_r      <= seen_nxt;
      deliv_r     <= deliv_nxt;
      drop_r      <= drop_nxt;
      wsum_r      <= wsum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tail_fin_r <= tail_fin_nxt;
    res_r      <= res_nxt;
    if (take) begin
      arr_r     <= in_arr_ext;
      start_r   <= in_gt ? tail_fin_r : in_arr_ext;
      wait_r    <= !in_gt ? '0 :
                   (in_diff[FIN_W-1:WAIT_W] != '0) ? WAIT_MAX : in_diff[WAIT_W-1:0];
      service_r <= SVC_W'(in_bytes) * SVC_W'(ticks_per_byte);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = res_r;

endmodule

// ----- sv/drop_tail_queue_delay_tracker_core.sv -----
`timescale 1ns / 1ps
// Timing: out_tvalid rises once the head packets retired for that arrival are out and
//   the commit has loaded the result register; a stalled result delays the commit.
// Flow: a new packet is taken only after the last one has committed; the retires
//   are paced by the single read port of the finish-time memory.
// Reset: synchronous, active low; clears pointers, counts and total wait,
//   loads the rate and limit defaults. The finish-time memory is not cleared.
// ----------------------------------------------------------------------------
// drop_tail_queue_delay_tracker_core
// Drop-tail FIFO ahead of a fixed-rate link: retires finished packets,
// measures each arrival's queueing delay, enqueues or drops it and reports
// running counts and the total delay.
// ----------------------------------------------------------------------------
module drop_tail_queue_delay_tracker_core
  import dtq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input transaction
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // arrival_time[47:0], packet_bytes[63:48]
  // Result transaction
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // wait_ticks[47:0], occupancy[55:48],
                                             // incoming_count[87:56],
                                             // delivered_count[119:88],
                                             // dropped_count[151:120],
                                             // total_wait[214:152], zero[215]
  output logic                   out_tuser,  // accepted
  // Configuration writes
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [TPB_W-1:0]  tpb_r;
  logic [QLIM_W-1:0] qlim_r;

  logic              mem_wr_en;
  logic [AW-1:0]     mem_wr_addr, mem_rd_addr;
  logic [FIN_W-1:0]  mem_wr_data, mem_rd_data;
  dtq_result_t       res;

  // Configuration registers: user writes with no transaction in flight; not enforced.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpb_r  <= TPB_RST;
      qlim_r <= QLIM_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_TPB:  tpb_r  <= cfg_wdata[TPB_W-1:0];
        REG_QLIM: qlim_r <= cfg_wdata[QLIM_W-1:0];
        default:  ;
      endcase
    end
  end

  // Sequencer: accept, retire the head while it has finished, then commit.
  dtq_engine #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .in_arrival     (in_tdata[ARR_W-1:0]),
    .in_bytes       (in_tdata[ARR_W +: BYTES_W]),
    .ticks_per_byte (tpb_r),
    .queue_limit    (qlim_r),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_result     (res),
    .mem_wr_en      (mem_wr_en),
    .mem_wr_addr    (mem_wr_addr),
    .mem_wr_data    (mem_wr_data),
    .mem_rd_addr    (mem_rd_addr),
    .mem_rd_data    (mem_rd_data)
  );

  // Ring of finish times, one entry per held packet.
  dtq_fin_mem #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW),
    .DW    (FIN_W)
  ) u_fin_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Pack the result record, lowest field first, pad to whole bytes.
  assign out_tdata = {1'b0,
                      res.total_wait,
                      res.dropped_count,
                      res.delivered_count,
                      res.incoming_count,
                      res.occupancy,
                      res.wait_ticks};
  assign out_tuser = res.accepted;

endmodule

// ----- sv/dtq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_checker
// Port-level checks on the drop-tail queue tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "drop_tail_queue_delay_tracker_core_assert.svh"

module dtq_checker
  import dtq_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser
);

  // A stalled result holds.
  `DTQ_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))

  // A dropped packet reports no delay.
  `DTQ_ASSERT(a_drop_no_wait, out_tvalid && !out_tuser |-> out_tdata[WAIT_W-1:0] == '0)

  // One packet at a time: the input closes after each transaction.
  `DTQ_ASSERT(a_in_busy, in_tvalid && in_tready |=> !in_tready)

  // Reset empties the result side.
  `DTQ_ASSERT_RST(a_rst_quiet, !rst_n |=> !out_tvalid)

endmodule

bind drop_tail_queue_delay_tracker_core dtq_checker u_dtq_checker (.*);
